// ===== design/dllc_pkg.sv =====
// Package for the doubly linked list cursor engine: request codes, defaults,
// node memory write bundle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dllc_pkg;
    localparam int NODES_DEF       = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int REQ_W           = 4;
    localparam int IN_DATA_W       = 40;
    localparam int OUT_DATA_W      = 104;

    localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd0;
    localparam logic [REQ_W-1:0] REQ_INS_FIRST  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_INS_LAST   = 4'd2;
    localparam logic [REQ_W-1:0] REQ_CUR_FIRST  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_CUR_LAST   = 4'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_FIRST  = 4'd5;
    localparam logic [REQ_W-1:0] REQ_DEL_LAST   = 4'd6;
    localparam logic [REQ_W-1:0] REQ_DEL_AFTER  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_DEL_BEFORE = 4'd8;
    localparam logic [REQ_W-1:0] REQ_INS_AFTER  = 4'd9;
    localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 4'd10;
    localparam logic [REQ_W-1:0] REQ_OVERWRITE  = 4'd11;
    localparam logic [REQ_W-1:0] REQ_NEXT       = 4'd12;
    localparam logic [REQ_W-1:0] REQ_PREV       = 4'd13;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 4'd14;

    // one write port per array; pointers as wide as the widest pool
    typedef struct packed {
        logic        val_we;
        logic [16:0] val_addr;
        logic [63:0] val_data;
        logic        nxt_we;
        logic [16:0] nxt_addr;
        logic [16:0] nxt_data;
        logic        prv_we;
        logic [16:0] prv_addr;
        logic [16:0] prv_data;
    } node_wr_t;
endpackage
`default_nettype wire

// ===== design/dllc_node_mem.sv =====
// Node pool storage: value, next and prev arrays, one shared read address,
// registered read data. Depends on dllc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dllc_node_mem #(
    parameter int NODES       = dllc_pkg::NODES_DEF,
    parameter int VALUE_WIDTH = dllc_pkg::VALUE_WIDTH_DEF
) (
    input  wire                         aclk,
    input  wire dllc_pkg::node_wr_t     wr,
    input  wire [$clog2(NODES)-1:0]     raddr,
    output logic [VALUE_WIDTH-1:0]      rd_val,
    output logic [$clog2(NODES):0]      rd_next,
    output logic [$clog2(NODES):0]      rd_prev
);
    localparam int AW = $clog2(NODES);
    localparam int PW = AW + 1;

    logic [VALUE_WIDTH-1:0] val_mem [NODES];
    logic [PW-1:0]          nxt_mem [NODES];
    logic [PW-1:0]          prv_mem [NODES];

    always_ff @(posedge aclk) begin
        if (wr.val_we) val_mem[wr.val_addr[AW-1:0]] <= wr.val_data[VALUE_WIDTH-1:0];
        if (wr.nxt_we) nxt_mem[wr.nxt_addr[AW-1:0]] <= wr.nxt_data[PW-1:0];
        if (wr.prv_we) prv_mem[wr.prv_addr[AW-1:0]] <= wr.prv_data[PW-1:0];
        rd_val  <= val_mem[raddr];
        rd_next <= nxt_mem[raddr];
        rd_prev <= prv_mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/doubly_linked_list_cursor_engine.sv =====
// Top level of the doubly linked list cursor engine: request sequencer,
// pointer and cached-value registers, result register. Uses dllc_pkg, dllc_node_mem.
//
//  channel  | dir | beat contents
//  s_axis   | in  | tdata[3:0] req_type, [35:4] write_value, [39:36] zero
//  m_axis   | out | tdata[0] status, [1] list_nonempty, [33:2] first_value,
//           |     |   [65:34] last_value, [66] cursor_valid, [98:67] cursor_value
//
// Each beat walks the sequencer states: queries, cursor jumps, overwrite, clear
// and dropped requests go straight to S_OUT; next/prev pass S_MV and S_VAL (not
// when stepping off an end); inserts pass S_AL, S_FREE when the free list is
// used, S_W1 and S_W2, after S_NB next to the cursor; deletes pass S_DT, S_DF and
// S_VAL when a new end node is left, after S_DN next to the cursor (ending when
// nothing lies there). Node memory reads are registered, so neighbor, free-list and new-end lookups go step by step.
// Reset (aresetn low, synchronous) empties the list at once; node memory needs
// no clearing pass. A new request is taken while the previous result is still
// held in the result register, as long as that result leaves in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module doubly_linked_list_cursor_engine #(
    parameter int NODES       = dllc_pkg::NODES_DEF,
    parameter int VALUE_WIDTH = dllc_pkg::VALUE_WIDTH_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [dllc_pkg::IN_DATA_W-1:0]     s_tdata,  // req_type, write_value
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // status, list_nonempty, first_value, last_value, cursor_valid, cursor_value
    output logic [dllc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    localparam int AW = $clog2(NODES);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] NIL = PW'(NODES);
    localparam int VW = VALUE_WIDTH;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NB   = 4'd1;  // neighbor of cursor arriving (insert)
    localparam logic [3:0] S_AL   = 4'd2;  // allocate node
    localparam logic [3:0] S_FREE = 4'd3;  // free-list link arriving
    localparam logic [3:0] S_W1   = 4'd4;  // write new node
    localparam logic [3:0] S_W2   = 4'd5;  // link neighbors to new node
    localparam logic [3:0] S_DN   = 4'd6;  // neighbor of cursor arriving (delete)
    localparam logic [3:0] S_DT   = 4'd7;  // links of victim arriving, unlink
    localparam logic [3:0] S_DF   = 4'd8;  // push victim onto free list
    localparam logic [3:0] S_MV   = 4'd9;  // cursor step
    localparam logic [3:0] S_VAL  = 4'd10; // value of new end/cursor arriving
    localparam logic [3:0] S_OUT  = 4'd11;

    localparam logic [1:0] VS_HEAD = 2'd0;
    localparam logic [1:0] VS_TAIL = 2'd1;
    localparam logic [1:0] VS_CUR  = 2'd2;

    logic [3:0]    state_reg;
    logic [dllc_pkg::REQ_W-1:0] req_reg;
    logic [VW-1:0] wval_reg;
    logic [PW-1:0] p_reg, q_reg, n_reg;
    logic [PW-1:0] head_reg, tail_reg, cur_reg, free_reg, fresh_reg;
    logic [VW-1:0] head_val_reg, tail_val_reg, cur_val_reg;
    logic [1:0]    vsel_reg;
    logic          status_reg;
    logic          m_valid_reg;
    logic [dllc_pkg::OUT_DATA_W-1:0] m_data_reg;

    dllc_pkg::node_wr_t wr;
    logic [PW-1:0] raddr;
    logic [VW-1:0] rd_val;
    logic [PW-1:0] rd_next, rd_prev;

    logic [dllc_pkg::REQ_W-1:0] in_req;
    logic [VW-1:0] in_val;
    logic          accept, cur_ok, pool_full, del_p_nil, del_q_nil;
    logic [PW-1:0] nb_ptr, step_ptr;

    assign in_req    = s_tdata[3:0];
    assign in_val    = VW'(signed'(s_tdata[35:4]));
    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cur_ok    = (cur_reg != NIL);
    assign pool_full = (free_reg == NIL) && (fresh_reg == NIL);
    assign nb_ptr    = (req_reg == dllc_pkg::REQ_DEL_AFTER) ? rd_next : rd_prev;
    assign step_ptr  = (req_reg == dllc_pkg::REQ_NEXT) ? rd_next : rd_prev;
    assign del_p_nil = (p_reg == NIL);
    assign del_q_nil = (q_reg == NIL);

    function automatic logic [31:0] out_val(input logic [PW-1:0] p, input logic [VW-1:0] v);
        logic [31:0] r;
        r = 32'(signed'(v));
        return (p == NIL) ? 32'd0 : r;
    endfunction

    dllc_node_mem #(.NODES(NODES), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
        .aclk    (aclk),
        .wr      (wr),
        .raddr   (raddr[AW-1:0]),
        .rd_val  (rd_val),
        .rd_next (rd_next),
        .rd_prev (rd_prev)
    );

    // memory address and write strobes
    always_comb begin
        wr    = '0;
        raddr = cur_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_req == dllc_pkg::REQ_DEL_FIRST)     raddr = head_reg;
                else if (in_req == dllc_pkg::REQ_DEL_LAST) raddr = tail_reg;
                if (accept && in_req == dllc_pkg::REQ_OVERWRITE && cur_ok) begin
                    wr.val_we   = 1'b1;
                    wr.val_addr = 17'(cur_reg);
                    wr.val_data = 64'(in_val);
                end
            end
            S_AL:   raddr = free_reg;
            S_W1: begin
                wr.val_we   = 1'b1;
                wr.val_addr = 17'(n_reg);
                wr.val_data = 64'(wval_reg);
                wr.nxt_we   = 1'b1;
                wr.nxt_addr = 17'(n_reg);
                wr.nxt_data = 17'(q_reg);
                wr.prv_we   = 1'b1;
                wr.prv_addr = 17'(n_reg);
                wr.prv_data = 17'(p_reg);
            end
            S_W2: begin
                wr.nxt_we   = (p_reg != NIL);
                wr.nxt_addr = 17'(p_reg);
                wr.nxt_data = 17'(n_reg);
                wr.prv_we   = (q_reg != NIL);
                wr.prv_addr = 17'(q_reg);
                wr.prv_data = 17'(n_reg);
            end
            S_DN:   raddr = nb_ptr;
            S_DT: begin
                wr.nxt_we   = (rd_prev != NIL);
                wr.nxt_addr = 17'(rd_prev);
                wr.nxt_data = 17'(rd_next);
                wr.prv_we   = (rd_next != NIL);
                wr.prv_addr = 17'(rd_next);
                wr.prv_data = 17'(rd_prev);
            end
            S_DF: begin
                wr.nxt_we   = 1'b1;
                wr.nxt_addr = 17'(n_reg);
                wr.nxt_data = 17'(free_reg);
                raddr       = del_p_nil ? q_reg : p_reg;
            end
            S_MV:   raddr = step_ptr;
            S_NB, S_FREE, S_VAL, S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NIL;
            tail_reg    <= NIL;
            cur_reg     <= NIL;
            free_reg    <= NIL;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (accept) begin
                    req_reg    <= in_req;
                    wval_reg   <= in_val;
                    status_reg <= 1'b0;
                    state_reg  <= S_OUT;
                    unique case (in_req)
                        dllc_pkg::REQ_CLEAR: begin
                            head_reg  <= NIL;
                            tail_reg  <= NIL;
                            cur_reg   <= NIL;
                            free_reg  <= NIL;
                            fresh_reg <= '0;
                        end
                        dllc_pkg::REQ_CUR_FIRST: begin
                            cur_reg     <= head_reg;
                            cur_val_reg <= head_val_reg;
                        end
                        dllc_pkg::REQ_CUR_LAST: begin
                            cur_reg     <= tail_reg;
                            cur_val_reg <= tail_val_reg;
                        end
                        dllc_pkg::REQ_INS_FIRST, dllc_pkg::REQ_INS_LAST: begin
                            p_reg <= (in_req == dllc_pkg::REQ_INS_LAST) ? tail_reg : NIL;
                            q_reg <= (in_req == dllc_pkg::REQ_INS_FIRST) ? head_reg : NIL;
                            if (pool_full) status_reg <= 1'b1;
                            else           state_reg  <= S_AL;
                        end
                        dllc_pkg::REQ_INS_AFTER, dllc_pkg::REQ_INS_BEFORE: begin
                            if (cur_ok) begin
                                if (pool_full) status_reg <= 1'b1;
                                else           state_reg  <= S_NB;
                            end
                        end
                        dllc_pkg::REQ_DEL_FIRST: begin
                            n_reg <= head_reg;
                            if (head_reg != NIL) state_reg <= S_DT;
                        end
                        dllc_pkg::REQ_DEL_LAST: begin
                            n_reg <= tail_reg;
                            if (tail_reg != NIL) state_reg <= S_DT;
                        end
                        dllc_pkg::REQ_DEL_AFTER, dllc_pkg::REQ_DEL_BEFORE: begin
                            if (cur_ok) state_reg <= S_DN;
                        end
                        dllc_pkg::REQ_OVERWRITE: begin
                            if (cur_ok) begin
                                cur_val_reg <= in_val;
                                if (head_reg == cur_reg) head_val_reg <= in_val;
                                if (tail_reg == cur_reg) tail_val_reg <= in_val;
                            end
                        end
                        dllc_pkg::REQ_NEXT: begin
                            if (cur_ok) begin
                                if (cur_reg == tail_reg) cur_reg   <= NIL;
                                else                     state_reg <= S_MV;
                            end
                        end
                        dllc_pkg::REQ_PREV: begin
                            if (cur_ok) begin
                                if (cur_reg == head_reg) cur_reg   <= NIL;
                                else                     state_reg <= S_MV;
                            end
                        end
                        default: ;  // query and the unused code
                    endcase
                end
                S_NB: begin
                    if (req_reg == dllc_pkg::REQ_INS_AFTER) begin
                        p_reg <= cur_reg;
                        q_reg <= rd_next;
                    end else begin
                        p_reg <= rd_prev;
                        q_reg <= cur_reg;
                    end
                    state_reg <= S_AL;
                end
                S_AL: begin
                    if (free_reg != NIL) begin
                        n_reg     <= free_reg;
                        state_reg <= S_FREE;
                    end else begin
                        n_reg     <= fresh_reg;
                        fresh_reg <= fresh_reg + 1'b1;
                        state_reg <= S_W1;
                    end
                end
                S_FREE: begin
                    free_reg  <= rd_next;
                    state_reg <= S_W1;
                end
                S_W1: begin
                    if (p_reg == NIL) begin
                        head_reg     <= n_reg;
                        head_val_reg <= wval_reg;
                    end
                    if (q_reg == NIL) begin
                        tail_reg     <= n_reg;
                        tail_val_reg <= wval_reg;
                    end
                    state_reg <= S_W2;
                end
                S_W2: state_reg <= S_OUT;
                S_DN: begin
                    n_reg     <= nb_ptr;
                    state_reg <= (nb_ptr == NIL) ? S_OUT : S_DT;
                end
                S_DT: begin
                    p_reg <= rd_prev;
                    q_reg <= rd_next;
                    if (rd_prev == NIL) head_reg <= rd_next;
                    if (rd_next == NIL) tail_reg <= rd_prev;
                    if (cur_reg == n_reg) cur_reg <= NIL;
                    state_reg <= S_DF;
                end
                S_DF: begin
                    free_reg <= n_reg;
                    if (del_p_nil && !del_q_nil) begin
                        vsel_reg  <= VS_HEAD;
                        state_reg <= S_VAL;
                    end else if (del_q_nil && !del_p_nil) begin
                        vsel_reg  <= VS_TAIL;
                        state_reg <= S_VAL;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_MV: begin
                    cur_reg   <= step_ptr;
                    vsel_reg  <= VS_CUR;
                    state_reg <= S_VAL;
                end
                S_VAL: begin
                    priority case (vsel_reg)
                        VS_HEAD: head_val_reg <= rd_val;
                        VS_TAIL: tail_val_reg <= rd_val;
                        default: cur_val_reg  <= rd_val;
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // slot is free here: acceptance in IDLE required it
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= {5'd0,
                                    out_val(cur_reg, cur_val_reg),
                                    cur_ok,
                                    out_val(tail_reg, tail_val_reg),
                                    out_val(head_reg, head_val_reg),
                                    (head_reg != NIL),
                                    status_reg};
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
`default_nettype wire

// ===== design/dllc_checker.sv =====
// Port-level checks for the doubly linked list cursor engine, bound to the
// top level. Depends on dllc_pkg widths.
`timescale 1ns / 1ps
`default_nettype none
module dllc_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire [dllc_pkg::IN_DATA_W-1:0]   s_tdata,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [dllc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_no_take_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result register is blocked");

    a_cursor_needs_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[66] && !m_tdata[1]))
        else $error("cursor valid on an empty list");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[65:2] == 64'd0)
        else $error("end values not zero on an empty list");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken before previous one finished");
endmodule

bind doubly_linked_list_cursor_engine dllc_checker u_dllc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
